>>> src/fsla_pkg.sv
`default_nettype none

package fsla_pkg;

    localparam int unsigned WORD_W         = 32;
    localparam int unsigned LINK_W         = 16;
    localparam int unsigned IDX_W          = 12;
    localparam int unsigned PAGE_WORDS_DEF = 4096;

    localparam logic [LINK_W-1:0] NO_LINK      = 16'hFFFF;
    localparam logic [IDX_W-1:0]  COUNT_MAX    = 12'hFFF;
    localparam logic [WORD_W-1:0] FREE_MARK_RST = 32'hFFFF_FFFF;

    // operation codes
    localparam logic [1:0] FUNC_ALLOC_HEAD = 2'd0;
    localparam logic [1:0] FUNC_ALLOC_AT   = 2'd1;
    localparam logic [1:0] FUNC_FREE       = 2'd2;

    // status codes
    localparam logic [1:0] STAT_OK         = 2'd0;
    localparam logic [1:0] STAT_NOT_FREE   = 2'd1;
    localparam logic [1:0] STAT_ALREADY    = 2'd2;
    localparam logic [1:0] STAT_RANGE      = 2'd3;

    typedef struct packed {
        logic [1:0]       func;
        logic [IDX_W-1:0] slot_index;
    } cmd_t;

    typedef struct packed {
        logic [1:0]       status;
        logic [IDX_W-1:0] result_index;
        logic [IDX_W-1:0] free_slots;
    } rsp_t;

    typedef struct packed {
        logic en;
        logic we;
    } mem_ctl_t;

    typedef enum logic [4:0] {
        S_CLEAR,
        S_IDLE,
        S_CHECK,
        S_MARK,
        S_SLOT,
        S_HEAD_NBR,
        S_HEAD_CLR,
        S_HEAD_RD,
        S_HEAD_WR,
        S_AT_PREV_RD,
        S_AT_PREV_WR,
        S_AT_NEXT_RD,
        S_AT_NEXT_WR,
        S_AT_CLR,
        S_FREE_HEAD,
        S_FREE_HMARK,
        S_FREE_LINK,
        S_FREE_MARK
    } fsla_state_t;

endpackage

`default_nettype wire

>>> src/fsla_mem.sv
`default_nettype none

// Single-port page store, registered read data.
module fsla_mem #(
    parameter int unsigned DEPTH = fsla_pkg::PAGE_WORDS_DEF,
    parameter int unsigned AW    = $clog2(DEPTH)
) (
    input  wire logic                          clk,
    input  wire fsla_pkg::mem_ctl_t            ctl,
    input  wire logic [AW-1:0]                 addr,
    input  wire logic [fsla_pkg::WORD_W-1:0]   wdata,
    output logic      [fsla_pkg::WORD_W-1:0]   rdata
);
    import fsla_pkg::*;

    logic [WORD_W-1:0] mem_array [DEPTH];
    logic [WORD_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.en)
        begin
            if (ctl.we)
            begin
                mem_array[addr] <= wdata;
            end
            else
            begin
                rdata_reg <= mem_array[addr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

>>> src/fsla_seq.sv
`default_nettype none

// Operation sequencer: walks the page store at most one access per cycle and
// runs the marker and link equality checks through one shared 32-bit compare.
module fsla_seq #(
    parameter int unsigned PAGE_WORDS = fsla_pkg::PAGE_WORDS_DEF,
    parameter int unsigned AW         = $clog2(PAGE_WORDS)
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire fsla_pkg::cmd_t                cmd,
    input  wire logic [fsla_pkg::WORD_W-1:0]   free_mark,
    output logic                               done,
    output fsla_pkg::rsp_t                     rsp,
    output fsla_pkg::mem_ctl_t                 mem_ctl,
    output logic      [AW-1:0]                 mem_addr,
    output logic      [fsla_pkg::WORD_W-1:0]   mem_wdata,
    input  wire logic [fsla_pkg::WORD_W-1:0]   mem_rdata
);
    import fsla_pkg::*;

    localparam int unsigned LW1 = LINK_W + 1;
    localparam logic [LW1-1:0] PW_LIM   = LW1'(PAGE_WORDS);
    localparam logic [AW-1:0]  CLR_LAST = AW'(PAGE_WORDS - 1);

    fsla_state_t       state_reg, state_next;
    logic [1:0]        func_reg, func_next;
    logic [LINK_W-1:0] slot_reg, slot_next;
    logic [WORD_W-1:0] word_reg, word_next;
    logic [LINK_W-1:0] head_reg, head_next;
    logic [IDX_W-1:0]  total_reg, total_next;
    logic [AW-1:0]     clr_cnt_reg, clr_cnt_next;
    logic              done_reg, done_next;
    rsp_t              rsp_reg, rsp_next;

    logic [LW1-1:0]    slot_p1;
    logic [LW1-1:0]    head_p1;
    logic [WORD_W-1:0] cmp_a;
    logic [WORD_W-1:0] cmp_b;
    logic              cmp_eq;
    logic              fin;
    logic [1:0]        fin_st;
    logic [LINK_W-1:0] rd_prev;
    logic [LINK_W-1:0] rd_next;
    logic [LINK_W-1:0] w_prev;
    logic [LINK_W-1:0] w_next;

    function automatic logic link_ok(input logic [LINK_W-1:0] l);
        link_ok = (l == NO_LINK) || ({1'b0, l} < PW_LIM);
    endfunction

    assign slot_p1 = {1'b0, slot_reg} + LW1'(1);
    assign head_p1 = {1'b0, head_reg} + LW1'(1);
    assign rd_prev = mem_rdata[WORD_W-1:LINK_W];
    assign rd_next = mem_rdata[LINK_W-1:0];
    assign w_prev  = word_reg[WORD_W-1:LINK_W];
    assign w_next  = word_reg[LINK_W-1:0];
    assign cmp_eq  = (cmp_a == cmp_b);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_CLEAR;
            head_reg    <= NO_LINK;
            total_reg   <= '0;
            clr_cnt_reg <= '0;
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            head_reg    <= head_next;
            total_reg   <= total_next;
            clr_cnt_reg <= clr_cnt_next;
            done_reg    <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg <= func_next;
        slot_reg <= slot_next;
        word_reg <= word_next;
        rsp_reg  <= rsp_next;
    end

    always_comb
    begin
        state_next   = state_reg;
        func_next    = func_reg;
        slot_next    = slot_reg;
        word_next    = word_reg;
        head_next    = head_reg;
        total_next   = total_reg;
        clr_cnt_next = clr_cnt_reg;
        done_next    = 1'b0;
        rsp_next     = rsp_reg;
        mem_ctl      = '0;
        mem_addr     = '0;
        mem_wdata    = '0;
        cmp_a        = mem_rdata;
        cmp_b        = free_mark;
        fin          = 1'b0;
        fin_st       = STAT_OK;

        unique case (state_reg)
            S_CLEAR:
            begin
                mem_ctl  = '{en: 1'b1, we: 1'b1};
                mem_addr = clr_cnt_reg;
                if (clr_cnt_reg == CLR_LAST)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    clr_cnt_next = clr_cnt_reg + AW'(1);
                end
            end

            S_IDLE:
            begin
                if (start)
                begin
                    func_next  = cmd.func;
                    slot_next  = (cmd.func == FUNC_ALLOC_HEAD) ? head_reg
                                                               : LINK_W'(cmd.slot_index);
                    state_next = S_CHECK;
                end
            end

            S_CHECK:
            begin
                case (func_reg) inside
                    FUNC_ALLOC_HEAD:
                    begin
                        if (total_reg == '0 || slot_reg == NO_LINK)
                        begin
                            fin = 1'b1; fin_st = STAT_NOT_FREE;
                        end
                        else if (slot_p1 >= PW_LIM)
                        begin
                            fin = 1'b1; fin_st = STAT_RANGE;
                        end
                        else
                        begin
                            mem_ctl    = '{en: 1'b1, we: 1'b0};
                            mem_addr   = slot_p1[AW-1:0];
                            state_next = S_MARK;
                        end
                    end
                    FUNC_ALLOC_AT, FUNC_FREE:
                    begin
                        if (slot_p1 >= PW_LIM)
                        begin
                            fin = 1'b1; fin_st = STAT_RANGE;
                        end
                        else if (func_reg == FUNC_ALLOC_AT && total_reg == '0)
                        begin
                            fin = 1'b1; fin_st = STAT_NOT_FREE;
                        end
                        else
                        begin
                            mem_ctl    = '{en: 1'b1, we: 1'b0};
                            mem_addr   = slot_p1[AW-1:0];
                            state_next = S_MARK;
                        end
                    end
                    default:
                    begin
                        fin = 1'b1; fin_st = STAT_NOT_FREE;
                    end
                endcase
            end

            // marker word of the slot is on mem_rdata
            S_MARK:
            begin
                if (func_reg == FUNC_FREE)
                begin
                    if (cmp_eq)
                    begin
                        fin = 1'b1; fin_st = STAT_ALREADY;
                    end
                    else if (total_reg == COUNT_MAX)
                    begin
                        fin = 1'b1; fin_st = STAT_NOT_FREE;
                    end
                    else if (head_reg == NO_LINK)
                    begin
                        if (total_reg != '0)
                        begin
                            fin = 1'b1; fin_st = STAT_NOT_FREE;
                        end
                        else
                        begin
                            state_next = S_FREE_LINK;
                        end
                    end
                    else if (total_reg == '0)
                    begin
                        fin = 1'b1; fin_st = STAT_NOT_FREE;
                    end
                    else if (head_p1 >= PW_LIM)
                    begin
                        fin = 1'b1; fin_st = STAT_RANGE;
                    end
                    else
                    begin
                        mem_ctl    = '{en: 1'b1, we: 1'b0};
                        mem_addr   = head_reg[AW-1:0];
                        state_next = S_FREE_HEAD;
                    end
                end
                else if (!cmp_eq)
                begin
                    fin = 1'b1; fin_st = STAT_NOT_FREE;
                end
                else
                begin
                    mem_ctl    = '{en: 1'b1, we: 1'b0};
                    mem_addr   = slot_reg[AW-1:0];
                    state_next = S_SLOT;
                end
            end

            // link word of the slot is on mem_rdata
            S_SLOT:
            begin
                word_next = mem_rdata;
                if (func_reg == FUNC_ALLOC_HEAD)
                begin
                    if (rd_prev != NO_LINK)
                    begin
                        fin = 1'b1; fin_st = STAT_NOT_FREE;
                    end
                    else if (!link_ok(rd_next))
                    begin
                        fin = 1'b1; fin_st = STAT_RANGE;
                    end
                    else if (rd_next != NO_LINK)
                    begin
                        if (total_reg <= IDX_W'(1))
                        begin
                            fin = 1'b1; fin_st = STAT_NOT_FREE;
                        end
                        else
                        begin
                            mem_ctl    = '{en: 1'b1, we: 1'b0};
                            mem_addr   = rd_next[AW-1:0];
                            state_next = S_HEAD_NBR;
                        end
                    end
                    else if (total_reg != IDX_W'(1))
                    begin
                        fin = 1'b1; fin_st = STAT_NOT_FREE;
                    end
                    else
                    begin
                        state_next = S_HEAD_CLR;
                    end
                end
                else
                begin
                    if (rd_prev == NO_LINK && head_reg != slot_reg)
                    begin
                        fin = 1'b1; fin_st = STAT_NOT_FREE;
                    end
                    else if (!link_ok(rd_prev) || !link_ok(rd_next))
                    begin
                        fin = 1'b1; fin_st = STAT_RANGE;
                    end
                    else
                    begin
                        state_next = S_AT_PREV_RD;
                    end
                end
            end

            // next slot's prev link must name the head
            S_HEAD_NBR:
            begin
                cmp_a = WORD_W'(rd_prev);
                cmp_b = WORD_W'(slot_reg);
                if (!cmp_eq)
                begin
                    fin = 1'b1; fin_st = STAT_NOT_FREE;
                end
                else
                begin
                    state_next = S_HEAD_CLR;
                end
            end

            S_HEAD_CLR:
            begin
                mem_ctl  = '{en: 1'b1, we: 1'b1};
                mem_addr = slot_p1[AW-1:0];
                if (w_next == NO_LINK)
                begin
                    fin = 1'b1;
                end
                else
                begin
                    state_next = S_HEAD_RD;
                end
            end

            // re-read: the marker clear may have hit this word
            S_HEAD_RD:
            begin
                mem_ctl    = '{en: 1'b1, we: 1'b0};
                mem_addr   = w_next[AW-1:0];
                state_next = S_HEAD_WR;
            end

            S_HEAD_WR:
            begin
                mem_ctl   = '{en: 1'b1, we: 1'b1};
                mem_addr  = w_next[AW-1:0];
                mem_wdata = {NO_LINK, rd_next};
                fin       = 1'b1;
            end

            S_AT_PREV_RD:
            begin
                if (w_prev != NO_LINK)
                begin
                    mem_ctl    = '{en: 1'b1, we: 1'b0};
                    mem_addr   = w_prev[AW-1:0];
                    state_next = S_AT_PREV_WR;
                end
                else
                begin
                    state_next = S_AT_NEXT_RD;
                end
            end

            S_AT_PREV_WR:
            begin
                mem_ctl    = '{en: 1'b1, we: 1'b1};
                mem_addr   = w_prev[AW-1:0];
                mem_wdata  = {rd_prev, w_next};
                state_next = S_AT_NEXT_RD;
            end

            S_AT_NEXT_RD:
            begin
                if (w_next != NO_LINK)
                begin
                    mem_ctl    = '{en: 1'b1, we: 1'b0};
                    mem_addr   = w_next[AW-1:0];
                    state_next = S_AT_NEXT_WR;
                end
                else
                begin
                    state_next = S_AT_CLR;
                end
            end

            S_AT_NEXT_WR:
            begin
                mem_ctl    = '{en: 1'b1, we: 1'b1};
                mem_addr   = w_next[AW-1:0];
                mem_wdata  = {w_prev, rd_next};
                state_next = S_AT_CLR;
            end

            S_AT_CLR:
            begin
                mem_ctl  = '{en: 1'b1, we: 1'b1};
                mem_addr = slot_p1[AW-1:0];
                fin      = 1'b1;
            end

            // old head's link word on mem_rdata: must be list front
            S_FREE_HEAD:
            begin
                cmp_a = WORD_W'(rd_prev);
                cmp_b = WORD_W'(NO_LINK);
                if (!cmp_eq)
                begin
                    fin = 1'b1; fin_st = STAT_NOT_FREE;
                end
                else
                begin
                    word_next  = mem_rdata;
                    mem_ctl    = '{en: 1'b1, we: 1'b0};
                    mem_addr   = head_p1[AW-1:0];
                    state_next = S_FREE_HMARK;
                end
            end

            S_FREE_HMARK:
            begin
                if (!cmp_eq)
                begin
                    fin = 1'b1; fin_st = STAT_NOT_FREE;
                end
                else
                begin
                    mem_ctl    = '{en: 1'b1, we: 1'b1};
                    mem_addr   = head_reg[AW-1:0];
                    mem_wdata  = {slot_reg, w_next};
                    state_next = S_FREE_LINK;
                end
            end

            S_FREE_LINK:
            begin
                mem_ctl    = '{en: 1'b1, we: 1'b1};
                mem_addr   = slot_reg[AW-1:0];
                mem_wdata  = {NO_LINK, head_reg};
                state_next = S_FREE_MARK;
            end

            S_FREE_MARK:
            begin
                mem_ctl   = '{en: 1'b1, we: 1'b1};
                mem_addr  = slot_p1[AW-1:0];
                mem_wdata = free_mark;
                fin       = 1'b1;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (fin)
        begin
            state_next = S_IDLE;
            done_next  = 1'b1;
            if (fin_st == STAT_OK)
            begin
                case (func_reg)
                    FUNC_ALLOC_HEAD:
                    begin
                        head_next  = w_next;
                        total_next = total_reg - IDX_W'(1);
                    end
                    FUNC_ALLOC_AT:
                    begin
                        if (w_prev == NO_LINK)
                        begin
                            head_next = w_next;
                        end
                        total_next = total_reg - IDX_W'(1);
                    end
                    FUNC_FREE:
                    begin
                        head_next  = slot_reg;
                        total_next = total_reg + IDX_W'(1);
                    end
                    default:
                    begin
                        total_next = total_reg;
                    end
                endcase
            end
            rsp_next.status       = fin_st;
            rsp_next.result_index = (fin_st == STAT_OK) ? slot_reg[IDX_W-1:0] : '0;
            rsp_next.free_slots   = total_next;
        end
    end

    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;
    assign rsp  = rsp_reg;

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> state_reg == S_IDLE)
        else $error("result strobe outside idle");

    a_count_on_done: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(total_reg) |-> done_reg && rsp_reg.status == STAT_OK)
        else $error("free count moved without a successful result");

    a_err_index: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg && rsp_reg.status != STAT_OK |-> rsp_reg.result_index == '0)
        else $error("error result carries an index");

    a_free_head: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg && rsp_reg.status == STAT_OK && func_reg == FUNC_FREE
        |-> head_reg == slot_reg)
        else $error("freed slot not at list head");

    a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_IDLE |-> !mem_ctl.we)
        else $error("page write while idle");

endmodule

`default_nettype wire

>>> src/fixed_slot_free_list_allocator_unit.sv
// Free-list slot allocator over a page of 32-bit words. Pulse start with an
// item on cmd while busy is low; exactly one result item follows, shown on
// rsp for a single cycle with done high, and it cannot be held off, so the
// receiver must take it in that cycle. From acceptance to done an item runs
// the range checks and then one access at a time of the single-port page
// store (slot marker, slot links, neighbour read-modify-writes); errors
// found early finish sooner. busy drops in the cycle that done is shown, so
// the next item may start then. After reset the page store is zeroed by a
// clearing pass over all PAGE_WORDS words, during which busy is high. The
// free marker register may be written any time the block is idle and takes
// effect for the next item.
`default_nettype none

module fixed_slot_free_list_allocator_unit #(
    parameter int unsigned PAGE_WORDS = fsla_pkg::PAGE_WORDS_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire fsla_pkg::cmd_t                cmd,
    output logic                               done,
    output fsla_pkg::rsp_t                     rsp,
    input  wire logic                          cfg_wr_en,
    input  wire logic [fsla_pkg::WORD_W-1:0]   cfg_wr_data
);
    import fsla_pkg::*;

    localparam int unsigned AW = $clog2(PAGE_WORDS);

    // free marker register, the one config register
    logic [WORD_W-1:0] mark_reg;

    mem_ctl_t          mem_ctl;
    logic [AW-1:0]     mem_addr;
    logic [WORD_W-1:0] mem_wdata;
    logic [WORD_W-1:0] mem_rdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mark_reg <= FREE_MARK_RST;
        end
        else if (cfg_wr_en)
        begin
            mark_reg <= cfg_wr_data;
        end
    end

    // sequencer: checks, link updates, counters, result register
    fsla_seq #(
        .PAGE_WORDS (PAGE_WORDS),
        .AW         (AW)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .cmd       (cmd),
        .free_mark (mark_reg),
        .done      (done),
        .rsp       (rsp),
        .mem_ctl   (mem_ctl),
        .mem_addr  (mem_addr),
        .mem_wdata (mem_wdata),
        .mem_rdata (mem_rdata)
    );

    // page store, one access per cycle
    fsla_mem #(
        .DEPTH (PAGE_WORDS),
        .AW    (AW)
    ) u_mem (
        .clk   (clk),
        .ctl   (mem_ctl),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

endmodule

`default_nettype wire
